### rtl/core/mpe_pkg.sv
// shared types, constants and helpers for the polynomial evaluator
`default_nettype none

package mpe_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned POWER_W   = 4;
    localparam int unsigned MAX_POWER = 15;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0]  term_coef;
        logic        [POWER_W-1:0] x_power;
        logic        [POWER_W-1:0] y_power;
        logic        [POWER_W-1:0] z_power;
        logic                      last_term;
    } mpe_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] running_sum;
        logic                     sum_final;
    } mpe_out_t;

    // request to the term unit
    typedef struct packed {
        logic [DATA_W-1:0]  coef;
        logic [POWER_W-1:0] x_pow;
        logic [POWER_W-1:0] y_pow;
        logic [POWER_W-1:0] z_pow;
    } mpe_term_req_t;

    // status back from the term unit
    typedef struct packed {
        logic busy;
        logic done;
    } mpe_term_stat_t;

    // exponents above the limit count as the limit
    function automatic logic [POWER_W-1:0] sat_power(input logic [POWER_W-1:0] p);
        logic [POWER_W-1:0] r;
        r = p;
        if (int'(p) > MAX_POWER)
        begin
            r = POWER_W'(MAX_POWER);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/multivariate_poly_evaluate.sv
// top level: sparse three-variable polynomial evaluator
`default_nettype none

// Evaluates a sparse polynomial in x, y and z at the point held in registers
// point_x (index 0), point_y (index 1) and point_z (index 2); writes to other
// indexes are dropped. Each input request is one term: signed coefficient,
// three 4-bit exponents and a last-term flag. The term value
// coef * x^a * y^b * z^c is built on a single 32x32 multiplier that applies
// one factor per cycle, then added to the accumulator; every term gives one
// output request carrying the running sum and a copy of the flag. After the
// last term the accumulator clears, so the next term starts a new polynomial.
// All arithmetic wraps modulo 2^32. in_stall stays high while a term is in
// flight, until its sum is written to the output register, so the block
// takes no new term before it is through with the last. A finished result
// that the consumer stalls is held in the output register and the block
// waits for the register to free before writing the next sum. Change the
// point only while no term is in flight.

module multivariate_poly_evaluate (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire mpe_pkg::mpe_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output mpe_pkg::mpe_out_t                     out_data,
    input  wire logic                             cfg_we,
    input  wire logic [mpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpe_pkg::DATA_W-1:0]       cfg_data
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // ready for a term
    localparam logic [1:0] ST_CALC = 2'd1;   // term unit multiplying
    localparam logic [1:0] ST_HOLD = 2'd2;   // term ready, output busy

    logic [1:0]                   state_reg, state_next;
    logic [mpe_pkg::DATA_W-1:0]   point_x_reg, point_y_reg, point_z_reg;
    logic [mpe_pkg::DATA_W-1:0]   acc_reg, acc_next;
    logic                         last_reg, last_next;
    logic                         out_valid_reg, out_valid_next;
    mpe_pkg::mpe_out_t            out_data_reg, out_data_next;

    logic                         in_take;
    logic                         out_free;
    logic                         emit;
    logic [mpe_pkg::DATA_W-1:0]   sum;
    logic [mpe_pkg::DATA_W-1:0]   term;
    mpe_pkg::mpe_term_req_t       term_req;
    mpe_pkg::mpe_term_stat_t      term_stat;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // configuration registers: the point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            point_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mpe_pkg::REG_POINT_X: point_x_reg <= cfg_data;
                mpe_pkg::REG_POINT_Y: point_y_reg <= cfg_data;
                mpe_pkg::REG_POINT_Z: point_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hand the term to the multiplier loop
    assign term_req.coef  = in_data.term_coef;
    assign term_req.x_pow = in_data.x_power;
    assign term_req.y_pow = in_data.y_power;
    assign term_req.z_pow = in_data.z_power;

    mpe_term_unit u_term (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_take),
        .req     (term_req),
        .point_x (point_x_reg),
        .point_y (point_y_reg),
        .point_z (point_z_reg),
        .stat    (term_stat),
        .term    (term)
    );

    // term value stays in the unit until the next start, so hold can reuse it
    assign sum = acc_reg + term;

    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (term_stat.done)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // accumulator, output register
    always_comb
    begin
        last_next      = last_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (in_take)
        begin
            last_next = in_data.last_term;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.running_sum = sum;
            out_data_next.sum_final   = last_reg;
            // polynomial complete: start the next one from zero
            acc_next = last_reg ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // multiplier loop only runs while the sequencer waits on it
    a_busy_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        term_stat.busy |-> (state_reg == ST_CALC))
        else $error("term unit busy outside calc state");

    // an accepted term starts the loop on the next cycle
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (term_stat.busy && state_reg == ST_CALC))
        else $error("accepted term did not start the term unit");

    // after the final term is written out the accumulator is clear
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_reg) |=> (acc_reg == '0 && out_data_reg.sum_final))
        else $error("accumulator not cleared after last term");

    // a result is only written into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result written over a pending output");

endmodule

`default_nettype wire

### rtl/core/mpe_term_unit.sv
// term unit: coef * x^a * y^b * z^c on one shared multiplier
`default_nettype none

module mpe_term_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire mpe_pkg::mpe_term_req_t        req,
    input  wire logic [mpe_pkg::DATA_W-1:0]    point_x,
    input  wire logic [mpe_pkg::DATA_W-1:0]    point_y,
    input  wire logic [mpe_pkg::DATA_W-1:0]    point_z,
    output mpe_pkg::mpe_term_stat_t            stat,
    output logic [mpe_pkg::DATA_W-1:0]         term
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [mpe_pkg::DATA_W-1:0]    prod_reg, prod_next;
    logic [mpe_pkg::POWER_W-1:0]   xr_reg, xr_next;
    logic [mpe_pkg::POWER_W-1:0]   yr_reg, yr_next;
    logic [mpe_pkg::POWER_W-1:0]   zr_reg, zr_next;
    logic [mpe_pkg::DATA_W-1:0]    base;
    logic [mpe_pkg::DATA_W-1:0]    mul_out;

    // pick the variable still owing a factor
    always_comb
    begin
        priority if (xr_reg != '0)
        begin
            base = point_x;
        end
        else if (yr_reg != '0)
        begin
            base = point_y;
        end
        else
        begin
            base = point_z;
        end
    end

    // the one multiplier, low word only
    assign mul_out = prod_reg * base;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        xr_next   = xr_reg;
        yr_next   = yr_reg;
        zr_next   = zr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            prod_next = req.coef;
            xr_next   = mpe_pkg::sat_power(req.x_pow);
            yr_next   = mpe_pkg::sat_power(req.y_pow);
            zr_next   = mpe_pkg::sat_power(req.z_pow);
        end
        else if (run_reg)
        begin
            priority if (xr_reg != '0)
            begin
                prod_next = mul_out;
                xr_next   = xr_reg - mpe_pkg::POWER_W'(1);
            end
            else if (yr_reg != '0)
            begin
                prod_next = mul_out;
                yr_next   = yr_reg - mpe_pkg::POWER_W'(1);
            end
            else if (zr_reg != '0)
            begin
                prod_next = mul_out;
                zr_next   = zr_reg - mpe_pkg::POWER_W'(1);
            end
            else
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            xr_reg   <= '0;
            yr_reg   <= '0;
            zr_reg   <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            xr_reg   <= xr_next;
            yr_reg   <= yr_next;
            zr_reg   <= zr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign term      = prod_reg;

endmodule

`default_nettype wire

### tb/multivariate_poly_evaluate_tb.sv
// testbench for the polynomial evaluator: directed table then random polynomials, self-checked
module multivariate_poly_evaluate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpe_pkg::*;

    // the index port is two bits wide, so one index has no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_TERMS = 1530;
    localparam int DRAIN_CYCLES = 20000;
    localparam int TAIL_CYCLES  = 60;    // longer than the slowest term
    localparam int REPORT_LIMIT = 100;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int NUM_DIR      = 27;

    typedef enum logic {ROW_TERM, ROW_POINT} row_kind_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // one line of the directed table: either a term request or a point register write
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [DATA_W-1:0]      value;   // coefficient for a term, register data for a write
        logic [POWER_W-1:0]     xp;
        logic [POWER_W-1:0]     yp;
        logic [POWER_W-1:0]     zp;
        logic                   last;
        logic                   typed;   // 1: want holds the sum, else the predictor gives it
        logic [DATA_W-1:0]      want;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    mpe_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    mpe_out_t              out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_data  = '0;

    // predictor state: the point and the sum of the polynomial in progress
    logic [DATA_W-1:0]     point_val [3] = '{default: '0};
    logic [DATA_W-1:0]     poly_acc      = '0;
    mpe_out_t              sum_q [$];
    mpe_out_t              head;

    int                    fail_count  = 0;
    int                    terms_sent  = 0;
    int                    burst_left  = 1;
    stall_mode_t           stall_mode  = STALL_NONE;
    int                    stall_left  = 0;
    int                    stall_tick  = 0;

    // directed table: zero point first, then small and extreme points, a change of x
    // in the middle of a polynomial, and a write to the index with no register
    stim_row_t dir_rows [NUM_DIR] = '{
        // x = y = z = 0: only all-zero exponents survive, 0^0 counts as 1
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0005, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1, 32'h0000_0005},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0007, 4'd1,  4'd0,  4'd0,  1'b1, 1'b1, 32'h0000_0005},
        '{ROW_TERM,  REG_POINT_X, 32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_POINT, REG_POINT_X, 32'h0000_0002, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_POINT, REG_POINT_Y, 32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_POINT, REG_POINT_Z, 32'h0000_0003, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_POINT, REG_UNUSED,  32'hDEAD_BEEF, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        // 2^15, then a sum that wraps past the largest positive value
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0001, 4'd15, 4'd0,  4'd0,  1'b1, 1'b1, 32'h0000_8000},
        '{ROW_TERM,  REG_POINT_X, 32'h7FFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1, 32'h7FFF_FFFF},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0001, 4'd0,  4'd0,  4'd0,  1'b1, 1'b1, 32'h8000_0000},
        // most negative coefficient times (-1)^15 wraps back onto itself
        '{ROW_TERM,  REG_POINT_X, 32'h8000_0000, 4'd0,  4'd15, 4'd0,  1'b1, 1'b1, 32'h8000_0000},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0001, 4'd0,  4'd0,  4'd2,  1'b1, 1'b1, 32'h0000_0009},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0003, 4'd1,  4'd1,  4'd1,  1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0002, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 32'h0},
        // extreme point
        '{ROW_POINT, REG_POINT_X, 32'h8000_0000, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_POINT, REG_POINT_Y, 32'h7FFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_POINT, REG_POINT_Z, 32'hFFFF_FFFF, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'hFFFF_FFFF, 4'd1,  4'd1,  4'd1,  1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0001, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 32'h0},
        // x changes while the polynomial is still open: earlier terms stay summed
        '{ROW_POINT, REG_POINT_X, 32'h0000_0003, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h0000_0001, 4'd2,  4'd0,  4'd0,  1'b1, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h8000_0000, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h7FFF_FFFF, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 32'h0},
        '{ROW_POINT, REG_POINT_X, 32'h0000_0000, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h7FFF_FFFF, 4'd0,  4'd1,  4'd0,  1'b1, 1'b0, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h7FFF_FFFF, 4'd3,  4'd0,  4'd0,  1'b1, 1'b1, 32'h0},
        '{ROW_TERM,  REG_POINT_X, 32'h8000_0000, 4'd0,  4'd0,  4'd0,  1'b0, 1'b1, 32'h8000_0000}
    };

    multivariate_poly_evaluate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // base^e by repeated multiplication, wrapping at 32 bits; exponent capped at the limit
    function automatic logic [DATA_W-1:0] raise_power(input logic [DATA_W-1:0] base,
                                                      input logic [POWER_W-1:0] e);
        logic [DATA_W-1:0] r;
        int unsigned       n;
        r = 1;
        n = e;
        if (n > MAX_POWER)
        begin
            n = MAX_POWER;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            r = r * base;
        end
        return r;
    endfunction

    // adds one term to the open polynomial and gives the result the block owes for it
    function automatic mpe_out_t next_sum(input mpe_in_t t);
        logic [DATA_W-1:0] v;
        mpe_out_t          r;
        v = t.term_coef;
        v = v * raise_power(point_val[REG_POINT_X], t.x_power);
        v = v * raise_power(point_val[REG_POINT_Y], t.y_power);
        v = v * raise_power(point_val[REG_POINT_Z], t.z_power);
        poly_acc = poly_acc + v;
        r.running_sum = poly_acc;
        r.sum_final = t.last_term;
        if (t.last_term)
        begin
            poly_acc = '0;
        end
        return r;
    endfunction

    // word mix: extremes, small signed values, anything
    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h8000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'hFFFF_FFFF;
            3: w = '0;
            4, 5: w = $urandom_range(0, 6) - 3;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // mostly short exponents to keep terms quick, now and then the full range
    function automatic logic [POWER_W-1:0] pick_power();
        logic [POWER_W-1:0] p;
        if ($urandom_range(0, 4) == 0)
        begin
            p = POWER_W'($urandom_range(0, 15));
        end
        else
        begin
            p = POWER_W'($urandom_range(0, 3));
        end
        return p;
    endfunction

    // offers one term request, holds it until taken, then queues its expected sum
    task automatic push_term(input mpe_in_t t, input logic typed, input logic [DATA_W-1:0] want);
        mpe_out_t e;
        int       gap;
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (in_stall !== 1'b0);
        e = next_sum(t);
        if (typed)
        begin
            e.running_sum = want;
        end
        sum_q.push_back(e);
        terms_sent++;
        // bursts of back-to-back requests with random gaps in between
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop sending and wait until every expected sum has come back
    task automatic drain_sums();
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        do @(posedge clk); while (sum_q.size() != 0);
    endtask

    // one register write; keep the enable high when another write follows directly
    task automatic write_point(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val,
                               input logic more);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_POINT_X: point_val[REG_POINT_X] = val;
            REG_POINT_Y: point_val[REG_POINT_Y] = val;
            REG_POINT_Z: point_val[REG_POINT_Z] = val;
            default: ;
        endcase
        if (!more)
        begin
            cfg_we <= 1'b0;
        end
    endtask

    // one to three writes to random registers, the empty index among them now and then
    task automatic move_point();
        int                   n;
        logic [CFG_IDX_W-1:0] idx;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                idx = REG_UNUSED;
            end
            else
            begin
                idx = CFG_IDX_W'($urandom_range(REG_POINT_X, REG_POINT_Z));
            end
            write_point(idx, pick_word(), i < n - 1);
        end
    endtask

    // output side: the stall mode is redrawn at random whenever its countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        else
        begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // every taken result is checked against the oldest expected sum
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (sum_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $error("result with nothing expected: running_sum %0d, sum_final %0b",
                           out_data.running_sum, out_data.sum_final);
                end
            end
            else
            begin
                head = sum_q.pop_front();
                if (out_data.running_sum !== head.running_sum)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $error("running_sum: expected %0d, got %0d",
                               head.running_sum, out_data.running_sum);
                    end
                end
                if (out_data.sum_final !== head.sum_final)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $error("sum_final: expected %0b, got %0b",
                               head.sum_final, out_data.sum_final);
                    end
                end
            end
        end
    end

    initial
    begin
        mpe_in_t t;
        int      poly_len;
        logic    ragged;
        int      drain;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table; register writes only once the block has gone quiet
        for (int r = 0; r < NUM_DIR; r++)
        begin
            if (dir_rows[r].kind == ROW_POINT)
            begin
                if (r == 0 || dir_rows[r - 1].kind != ROW_POINT)
                begin
                    drain_sums();
                end
                write_point(dir_rows[r].idx, dir_rows[r].value,
                            r + 1 < NUM_DIR && dir_rows[r + 1].kind == ROW_POINT);
            end
            else
            begin
                t.term_coef = dir_rows[r].value;
                t.x_power   = dir_rows[r].xp;
                t.y_power   = dir_rows[r].yp;
                t.z_power   = dir_rows[r].zp;
                t.last_term = dir_rows[r].last;
                push_term(t, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // random polynomials of one to eight terms; a few have the last flag scattered
        while (terms_sent < NUM_DIR + RANDOM_TERMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                drain_sums();
                move_point();
            end
            poly_len = $urandom_range(1, 8);
            ragged = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < poly_len; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    // point moves inside an open polynomial
                    drain_sums();
                    move_point();
                end
                else if ($urandom_range(0, 59) == 0)
                begin
                    drain_sums();
                end
                t.term_coef = pick_word();
                t.x_power   = pick_power();
                t.y_power   = pick_power();
                t.z_power   = pick_power();
                t.last_term = ragged ? ($urandom_range(0, 3) == 0) : (k == poly_len - 1);
                push_term(t, 1'b0, '0);
            end
        end

        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        for (drain = 0; drain < DRAIN_CYCLES && sum_q.size() != 0; drain++)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sum_q.size() != 0)
        begin
            $error("%0d expected sums never arrived", sum_q.size());
            fail_count += sum_q.size();
        end

        if (fail_count == 0)
        begin
            $display("multivariate_poly_evaluate_tb OK");
        end
        else
        begin
            $display("multivariate_poly_evaluate_tb NOT OK");
        end
        $finish;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("multivariate_poly_evaluate_tb NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/core/mpe_pkg.sv
rtl/core/mpe_term_unit.sv
rtl/core/multivariate_poly_evaluate.sv
tb/multivariate_poly_evaluate_tb.sv
